[design/tsak_pkg.sv]
// Shared types, codes and saturation helper for the two-state angle Kalman core.
package tsak_pkg;

   localparam logic [1:0] CSR_ANGLE_NOISE = 2'd0;
   localparam logic [1:0] CSR_BIAS_NOISE  = 2'd1;
   localparam logic [1:0] CSR_MEAS_NOISE  = 2'd2;
   localparam logic [1:0] CSR_TIME_STEP   = 2'd3;

   typedef enum logic [3:0] {
      MUL_RATE_DT, MUL_DAA_DT, MUL_NBB_DT, MUL_BPN_DT,
      MUL_K0_PAA, MUL_K0_PAB, MUL_K1_PAA, MUL_K1_PAB, MUL_K0_ERR, MUL_K1_ERR
   } mul_sel_type;

   typedef enum logic [3:0] {
      ACC_NONE, ACC_ANG, ACC_PAA, ACC_PAB_PBA, ACC_PBB,
      ACC_CAA, ACC_CAB, ACC_CBA, ACC_CBB, ACC_BIAS
   } acc_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_DIV,
      ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7, ST_OUT
   } state_type;

   typedef struct packed {
      logic        load;
      logic        prep;
      mul_sel_type mul_sel;
      acc_sel_type acc_sel;
      logic        div_start;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic out_busy;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
      logic signed [31:0] r;
      if (x > 68'sh7FFFFFFF) begin
         r = 32'sh7FFFFFFF;
      end else if (x < -68'sh80000000) begin
         r = -32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

[design/two_state_angle_kalman_core.sv]
// Top level of the two-state (angle, gyro bias) Kalman filter core.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_tvalid/req_tready | tdata[31:0] accel_angle, [63:32] gyro_rate
//   rsp     | out | rsp_tvalid/rsp_tready | tdata[31:0] angle_estimate, [63:32] rate_estimate
//   csr     | in  | csr_we                | csr_addr register index, csr_wdata 31-bit value
//
// The bit-serial gain divider sets most of the time from acceptance to the result
// register, and the single shared multiplier is used for ten products in sequence.
// Reset is synchronous: it restores the register defaults, zero angle and bias
// and unit covariance. A stalled rsp holds the finished transaction while the
// next one is taken and computed; only its write-back waits for the slot.
module two_state_angle_kalman_core #(
   parameter int COV_FRAC_BITS = 30
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] accel_angle, [63:32] gyro_rate
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] angle_estimate, [63:32] rate_estimate
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [30:0] csr_wdata
);
   import tsak_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequence the steps of one transaction
   tsak_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // hold state, config and arithmetic
   tsak_dp #(.COV_FRAC_BITS(COV_FRAC_BITS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[design/tsak_div.sv]
// Two-lane restoring divider for the Kalman gains, one quotient bit per cycle.
module tsak_div #(
   parameter int COV_FRAC_BITS = 30
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [31:0]  num0,
   input  logic signed [31:0]  num1,
   input  logic signed [33:0]  den,
   output logic                busy,
   output logic signed [31:0]  k0,
   output logic signed [31:0]  k1
);
   import tsak_pkg::*;

   localparam int DVD = 32 + COV_FRAC_BITS;
   localparam int CW  = $clog2(DVD + 1);

   logic [DVD-1:0] dvd0_ff, dvd0_in, dvd1_ff, dvd1_in;
   logic [33:0]    rem0_ff, rem0_in, rem1_ff, rem1_in;
   logic [33:0]    den_ff, den_in;
   logic           neg0_ff, neg0_in, neg1_ff, neg1_in, zero_ff, zero_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic [33:0]    t0, t1;
   logic [32:0]    mag0, mag1;
   logic signed [67:0] q0s, q1s;

   always_comb begin
      dvd0_in = dvd0_ff; dvd1_in = dvd1_ff;
      rem0_in = rem0_ff; rem1_in = rem1_ff;
      den_in  = den_ff;
      neg0_in = neg0_ff; neg1_in = neg1_ff; zero_in = zero_ff;
      cnt_in  = cnt_ff;  busy_in = busy_ff;
      mag0 = num0[31] ? 33'(-34'(num0)) : 33'(num0);
      mag1 = num1[31] ? 33'(-34'(num1)) : 33'(num1);
      t0 = {rem0_ff[32:0], dvd0_ff[DVD-1]};
      t1 = {rem1_ff[32:0], dvd1_ff[DVD-1]};
      if (start) begin
         dvd0_in = DVD'(mag0) << COV_FRAC_BITS;
         dvd1_in = DVD'(mag1) << COV_FRAC_BITS;
         rem0_in = '0; rem1_in = '0;
         den_in  = den;
         neg0_in = num0[31]; neg1_in = num1[31];
         zero_in = (den <= 34'sd0);
         cnt_in  = CW'(DVD);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // quotient bits shift into the low end of the dividend registers
         if (t0 >= den_ff) begin
            rem0_in = t0 - den_ff;
            dvd0_in = {dvd0_ff[DVD-2:0], 1'b1};
         end else begin
            rem0_in = t0;
            dvd0_in = {dvd0_ff[DVD-2:0], 1'b0};
         end
         if (t1 >= den_ff) begin
            rem1_in = t1 - den_ff;
            dvd1_in = {dvd1_ff[DVD-2:0], 1'b1};
         end else begin
            rem1_in = t1;
            dvd1_in = {dvd1_ff[DVD-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd0_ff <= dvd0_in; dvd1_ff <= dvd1_in;
      rem0_ff <= rem0_in; rem1_ff <= rem1_in;
      den_ff  <= den_in;
      neg0_ff <= neg0_in; neg1_ff <= neg1_in; zero_ff <= zero_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_comb begin
      q0s = $signed(68'(dvd0_ff));
      q1s = $signed(68'(dvd1_ff));
      k0 = zero_ff ? 32'sd0 : sat32(neg0_ff ? -q0s : q0s);
      k1 = zero_ff ? 32'sd0 : sat32(neg1_ff ? -q1s : q1s);
   end

   assign busy = busy_ff;

endmodule

[design/tsak_dp.sv]
// Datapath: filter state, config registers, shared multiplier, gain divider, output register.
module tsak_dp #(
   parameter int COV_FRAC_BITS = 30
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tsak_pkg::cmd_type    cmd,
   output tsak_pkg::sts_type    sts,
   input  logic                 csr_we,
   input  logic [1:0]           csr_addr,
   input  logic [30:0]          csr_wdata,
   input  logic [63:0]          req_tdata,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [63:0]          rsp_tdata
);
   import tsak_pkg::*;

   localparam logic [30:0] APN_RST = 31'(((64'd1 << COV_FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic [30:0] BPN_RST = 31'(((64'd3 << COV_FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic [30:0] MN_RST  = 31'(64'd1 << (COV_FRAC_BITS - 1));
   localparam logic [30:0] DT_RST  = 31'(((64'd5 << COV_FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic signed [31:0] ONE_COV = 32'(64'd1 << COV_FRAC_BITS);
   localparam logic signed [67:0] RND = 68'sd1 <<< (COV_FRAC_BITS - 1);

   logic [30:0] apn_ff, bpn_ff, mn_ff, dt_ff;
   logic signed [31:0] ang_ff, ang_in, bias_ff, bias_in;
   logic signed [31:0] caa_ff, caa_in, cab_ff, cab_in, cba_ff, cba_in, cbb_ff, cbb_in;
   logic signed [31:0] paa_ff, paa_in, pab_ff, pab_in, pba_ff, pba_in, pbb_ff, pbb_in;
   logic signed [31:0] acc_ff, gyr_ff, rate_ff, daa_ff, err_ff, err_in;
   logic signed [65:0] prod_ff;
   logic signed [32:0] op_a, op_b, dt_op;
   logic signed [67:0] post_w;
   logic signed [31:0] post;
   logic signed [31:0] k0, k1;
   logic signed [33:0] den;
   logic               div_busy;
   logic               out_v_ff;
   logic [63:0]        out_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         apn_ff <= APN_RST; bpn_ff <= BPN_RST; mn_ff <= MN_RST; dt_ff <= DT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_ANGLE_NOISE: apn_ff <= csr_wdata;
            CSR_BIAS_NOISE:  bpn_ff <= csr_wdata;
            CSR_MEAS_NOISE:  mn_ff  <= csr_wdata;
            CSR_TIME_STEP:   dt_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // shared multiplier operand select
   always_comb begin
      dt_op = $signed({2'b00, dt_ff});
      op_a = 33'(rate_ff);
      op_b = dt_op;
      case (cmd.mul_sel)
         MUL_RATE_DT: begin op_a = 33'(rate_ff);           op_b = dt_op; end
         MUL_DAA_DT:  begin op_a = 33'(daa_ff);            op_b = dt_op; end
         MUL_NBB_DT:  begin op_a = -33'(cbb_ff);           op_b = dt_op; end
         MUL_BPN_DT:  begin op_a = $signed({2'b00, bpn_ff}); op_b = dt_op; end
         MUL_K0_PAA:  begin op_a = 33'(k0); op_b = 33'(paa_ff); end
         MUL_K0_PAB:  begin op_a = 33'(k0); op_b = 33'(pab_ff); end
         MUL_K1_PAA:  begin op_a = 33'(k1); op_b = 33'(paa_ff); end
         MUL_K1_PAB:  begin op_a = 33'(k1); op_b = 33'(pab_ff); end
         MUL_K0_ERR:  begin op_a = 33'(k0); op_b = 33'(err_ff); end
         MUL_K1_ERR:  begin op_a = 33'(k1); op_b = 33'(err_ff); end
         default: ;
      endcase
      post_w = (68'(prod_ff) + RND) >>> COV_FRAC_BITS;
      post   = sat32(post_w);
   end

   // add or subtract the registered product to update its target; ACC_PBB also forms the error
   always_comb begin
      ang_in = ang_ff; bias_in = bias_ff;
      caa_in = caa_ff; cab_in = cab_ff; cba_in = cba_ff; cbb_in = cbb_ff;
      paa_in = paa_ff; pab_in = pab_ff; pba_in = pba_ff; pbb_in = pbb_ff;
      err_in = err_ff;
      case (cmd.acc_sel)
         ACC_ANG:     ang_in = sat32(68'(ang_ff) + 68'(post));
         ACC_PAA:     paa_in = sat32(68'(caa_ff) + 68'(post));
         ACC_PAB_PBA: begin
            pab_in = sat32(68'(cab_ff) + 68'(post));
            pba_in = sat32(68'(cba_ff) + 68'(post));
         end
         ACC_PBB: begin
            pbb_in = sat32(68'(cbb_ff) + 68'(post));
            err_in = sat32(68'(acc_ff) - 68'(ang_ff));
         end
         ACC_CAA:  caa_in = sat32(68'(paa_ff) - 68'(post));
         ACC_CAB:  cab_in = sat32(68'(pab_ff) - 68'(post));
         ACC_CBA:  cba_in = sat32(68'(pba_ff) - 68'(post));
         ACC_CBB:  cbb_in = sat32(68'(pbb_ff) - 68'(post));
         ACC_BIAS: bias_in = sat32(68'(bias_ff) + 68'(post));
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 66'(op_a) * 66'(op_b);
      paa_ff <= paa_in; pab_ff <= pab_in; pba_ff <= pba_in; pbb_ff <= pbb_in;
      err_ff <= err_in;
      if (cmd.load) begin
         acc_ff <= req_tdata[31:0];
         gyr_ff <= req_tdata[63:32];
      end
      if (cmd.prep) begin
         rate_ff <= sat32(68'(gyr_ff) - 68'(bias_ff));
         daa_ff  <= sat32(68'(apn_ff) - 68'(cab_ff) - 68'(cba_ff));
      end
      if (cmd.out_load) begin
         out_d_ff <= {sat32(68'(gyr_ff) - 68'(bias_ff)), ang_ff};
      end
      if (reset) begin
         ang_ff <= '0; bias_ff <= '0;
         caa_ff <= ONE_COV; cab_ff <= '0; cba_ff <= '0; cbb_ff <= ONE_COV;
         out_v_ff <= 1'b0;
      end else begin
         ang_ff <= ang_in; bias_ff <= bias_in;
         caa_ff <= caa_in; cab_ff <= cab_in; cba_ff <= cba_in; cbb_ff <= cbb_in;
         if (cmd.out_load) begin
            out_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   assign den = 34'(mn_ff) + 34'(paa_ff);

   tsak_div #(.COV_FRAC_BITS(COV_FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num0  (paa_ff),
      .num1  (pba_ff),
      .den   (den),
      .busy  (div_busy),
      .k0    (k0),
      .k1    (k1)
   );

   assign sts          = '{div_busy: div_busy, out_busy: out_v_ff & ~rsp_tready};
   assign rsp_tvalid   = out_v_ff;
   assign rsp_tdata    = out_d_ff;

endmodule

[design/tsak_ctrl.sv]
// Sequencer that steps the datapath through predict, gain and correct.
module tsak_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  tsak_pkg::sts_type sts,
   output tsak_pkg::cmd_type cmd
);
   import tsak_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd.load      = 1'b0;
      cmd.prep      = 1'b0;
      cmd.mul_sel   = MUL_RATE_DT;
      cmd.acc_sel   = ACC_NONE;
      cmd.div_start = 1'b0;
      cmd.out_load  = 1'b0;
      req_tready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin cmd.prep = 1'b1; state_in = ST_P1; end
         ST_P1: begin cmd.mul_sel = MUL_RATE_DT; state_in = ST_P2; end
         ST_P2: begin cmd.mul_sel = MUL_DAA_DT; cmd.acc_sel = ACC_ANG; state_in = ST_P3; end
         ST_P3: begin cmd.mul_sel = MUL_NBB_DT; cmd.acc_sel = ACC_PAA; state_in = ST_P4; end
         ST_P4: begin
            cmd.mul_sel = MUL_BPN_DT; cmd.acc_sel = ACC_PAB_PBA; state_in = ST_P5;
         end
         ST_P5: begin cmd.acc_sel = ACC_PBB; cmd.div_start = 1'b1; state_in = ST_DIV; end
         ST_DIV: begin
            if (!sts.div_busy) begin
               state_in = ST_C1;
            end
         end
         ST_C1: begin cmd.mul_sel = MUL_K0_PAA; state_in = ST_C2; end
         ST_C2: begin cmd.mul_sel = MUL_K0_PAB; cmd.acc_sel = ACC_CAA; state_in = ST_C3; end
         ST_C3: begin cmd.mul_sel = MUL_K1_PAA; cmd.acc_sel = ACC_CAB; state_in = ST_C4; end
         ST_C4: begin cmd.mul_sel = MUL_K1_PAB; cmd.acc_sel = ACC_CBA; state_in = ST_C5; end
         ST_C5: begin cmd.mul_sel = MUL_K0_ERR; cmd.acc_sel = ACC_CBB; state_in = ST_C6; end
         ST_C6: begin cmd.mul_sel = MUL_K1_ERR; cmd.acc_sel = ACC_ANG; state_in = ST_C7; end
         ST_C7: begin cmd.acc_sel = ACC_BIAS; state_in = ST_OUT; end
         ST_OUT: begin
            if (!sts.out_busy) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[design/tsak_checker.sv]
// Port-level checks for the Kalman core, bound to the top level.
module tsak_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transaction taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind two_state_angle_kalman_core tsak_checker u_tsak_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
